### hdl/rc2_pkg.sv
// rc2_pkg: shared types, codes, the PI permutation and rotate helpers
// for the RC2 cipher engine. No dependencies.
package rc2_pkg;

  localparam logic [1:0] OP_WRITE   = 2'd0;
  localparam logic [1:0] OP_EXPAND  = 2'd1;
  localparam logic [1:0] OP_ENCRYPT = 2'd2;
  localparam logic [1:0] OP_DECRYPT = 2'd3;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_LEN_ZERO = 2'd1;
  localparam logic [1:0] STAT_LEN_LONG = 2'd2;
  localparam logic [1:0] STAT_EFF_LONG = 2'd3;

  localparam logic CFG_KEY_LENGTH = 1'b0;
  localparam logic CFG_EFF_BITS   = 1'b1;

  localparam logic [7:0]  KEY_LENGTH_RST = 8'd16;
  localparam logic [10:0] EFF_BITS_RST   = 11'd128;
  localparam logic [7:0]  MAX_KEY_BYTES  = 8'd128;

  typedef struct packed {
    logic [1:0]  operation;
    logic [6:0]  key_index;
    logic [7:0]  key_byte;
    logic [63:0] block_in;
  } in_t;

  typedef struct packed {
    logic [63:0] block_out;
    logic [1:0]  status;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_COPY, ST_FWD, ST_MASK, ST_BWD, ST_PACK, ST_CIPH, ST_MASH, ST_DONE
  } state_t;

  localparam logic [7:0] PI_TABLE [256] = '{
    8'hD9, 8'h78, 8'hF9, 8'hC4, 8'h19, 8'hDD, 8'hB5, 8'hED,
    8'h28, 8'hE9, 8'hFD, 8'h79, 8'h4A, 8'hA0, 8'hD8, 8'h9D,
    8'hC6, 8'h7E, 8'h37, 8'h83, 8'h2B, 8'h76, 8'h53, 8'h8E,
    8'h62, 8'h4C, 8'h64, 8'h88, 8'h44, 8'h8B, 8'hFB, 8'hA2,
    8'h17, 8'h9A, 8'h59, 8'hF5, 8'h87, 8'hB3, 8'h4F, 8'h13,
    8'h61, 8'h45, 8'h6D, 8'h8D, 8'h09, 8'h81, 8'h7D, 8'h32,
    8'hBD, 8'h8F, 8'h40, 8'hEB, 8'h86, 8'hB7, 8'h7B, 8'h0B,
    8'hF0, 8'h95, 8'h21, 8'h22, 8'h5C, 8'h6B, 8'h4E, 8'h82,
    8'h54, 8'hD6, 8'h65, 8'h93, 8'hCE, 8'h60, 8'hB2, 8'h1C,
    8'h73, 8'h56, 8'hC0, 8'h14, 8'hA7, 8'h8C, 8'hF1, 8'hDC,
    8'h12, 8'h75, 8'hCA, 8'h1F, 8'h3B, 8'hBE, 8'hE4, 8'hD1,
    8'h42, 8'h3D, 8'hD4, 8'h30, 8'hA3, 8'h3C, 8'hB6, 8'h26,
    8'h6F, 8'hBF, 8'h0E, 8'hDA, 8'h46, 8'h69, 8'h07, 8'h57,
    8'h27, 8'hF2, 8'h1D, 8'h9B, 8'hBC, 8'h94, 8'h43, 8'h03,
    8'hF8, 8'h11, 8'hC7, 8'hF6, 8'h90, 8'hEF, 8'h3E, 8'hE7,
    8'h06, 8'hC3, 8'hD5, 8'h2F, 8'hC8, 8'h66, 8'h1E, 8'hD7,
    8'h08, 8'hE8, 8'hEA, 8'hDE, 8'h80, 8'h52, 8'hEE, 8'hF7,
    8'h84, 8'hAA, 8'h72, 8'hAC, 8'h35, 8'h4D, 8'h6A, 8'h2A,
    8'h96, 8'h1A, 8'hD2, 8'h71, 8'h5A, 8'h15, 8'h49, 8'h74,
    8'h4B, 8'h9F, 8'hD0, 8'h5E, 8'h04, 8'h18, 8'hA4, 8'hEC,
    8'hC2, 8'hE0, 8'h41, 8'h6E, 8'h0F, 8'h51, 8'hCB, 8'hCC,
    8'h24, 8'h91, 8'hAF, 8'h50, 8'hA1, 8'hF4, 8'h70, 8'h39,
    8'h99, 8'h7C, 8'h3A, 8'h85, 8'h23, 8'hB8, 8'hB4, 8'h7A,
    8'hFC, 8'h02, 8'h36, 8'h5B, 8'h25, 8'h55, 8'h97, 8'h31,
    8'h2D, 8'h5D, 8'hFA, 8'h98, 8'hE3, 8'h8A, 8'h92, 8'hAE,
    8'h05, 8'hDF, 8'h29, 8'h10, 8'h67, 8'h6C, 8'hBA, 8'hC9,
    8'hD3, 8'h00, 8'hE6, 8'hCF, 8'hE1, 8'h9E, 8'hA8, 8'h2C,
    8'h63, 8'h16, 8'h01, 8'h3F, 8'h58, 8'hE2, 8'h89, 8'hA9,
    8'h0D, 8'h38, 8'h34, 8'h1B, 8'hAB, 8'h33, 8'hFF, 8'hB0,
    8'hBB, 8'h48, 8'h0C, 8'h5F, 8'hB9, 8'hB1, 8'hCD, 8'h2E,
    8'hC5, 8'hF3, 8'hDB, 8'h47, 8'hE5, 8'hA5, 8'h9C, 8'h77,
    8'h0A, 8'hA6, 8'h20, 8'h68, 8'hFE, 8'h7F, 8'hC1, 8'hAD
  };

  // Word w rotates by 1, 2, 3 or 5.
  function automatic logic [15:0] rotl16(input logic [15:0] x, input logic [1:0] w);
    logic [15:0] y;
    case (w)
      2'd0:    y = {x[14:0], x[15]};
      2'd1:    y = {x[13:0], x[15:14]};
      2'd2:    y = {x[12:0], x[15:13]};
      default: y = {x[10:0], x[15:11]};
    endcase
    return y;
  endfunction

  function automatic logic [15:0] rotr16(input logic [15:0] x, input logic [1:0] w);
    logic [15:0] y;
    case (w)
      2'd0:    y = {x[0], x[15:1]};
      2'd1:    y = {x[1:0], x[15:2]};
      2'd2:    y = {x[2:0], x[15:3]};
      default: y = {x[4:0], x[15:5]};
    endcase
    return y;
  endfunction

endpackage

### hdl/rc2_block_cipher.sv
// rc2_block_cipher: RC2 engine, key store, key schedule and block cipher
// on one shared round unit. Depends on rc2_pkg.
//
// Key byte write: no result; the engine stays ready.
// Encrypt/decrypt: each of the 64 mixing steps and 8 mashing steps is an
//   expanded key memory read, then one round-unit update. One block at a time.
// Expand: the key schedule passes through one read port on the 128-byte work
//   buffer; a failed check skips the buffers and goes straight to the result.
// Synchronous active-low reset returns control and the configuration registers to
//   their reset values; the key stores are undefined until written.
module rc2_block_cipher (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  rc2_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output rc2_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [10:0]   cfg_wdata
);
  import rc2_pkg::*;

  state_t state_r, state_nxt;
  logic [1:0]  ph_r, ph_nxt;        // sub-phase inside a step
  logic [7:0]  idx_r, idx_nxt;      // byte index / mash word counter
  logic [5:0]  cnt_r, cnt_nxt;      // mixing step / packed word counter
  logic [7:0]  prev_r, prev_nxt;    // last byte written to the work buffer
  logic [7:0]  lo_r, lo_nxt;
  logic        dec_r, dec_nxt;
  logic [1:0]  stat_r, stat_nxt;
  logic [15:0] r_r [4];
  logic [15:0] r_nxt [4];
  logic        out_valid_r, out_valid_nxt;
  out_t        out_data_r, out_data_nxt;
  logic [7:0]  key_length_r;
  logic [10:0] eff_bits_r;

  // Memories
  logic [7:0]  raw_mem [128];
  logic [7:0]  l_mem [128];
  logic [15:0] ek_mem [64];
  logic [7:0]  raw_q, l_q;
  logic [15:0] ek_q;
  logic        raw_we, l_we, ek_we;
  logic [6:0]  l_raddr, l_waddr;
  logic [7:0]  l_wdata;
  logic [5:0]  ek_raddr;

  logic        in_fire, out_free;
  logic [1:0]  exp_stat;
  logic [8:0]  t8_w;
  logic [7:0]  t8, mask_pos, tm;
  logic        copy_last, fwd_last, bwd_last, pack_last, mash_point, mash_last;
  logic [7:0]  pi_idx, pi_val;
  logic [1:0]  wi, wa, wb, wc, wm;
  logic [15:0] mixv;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // Key schedule checks and derived sizes.
  always_comb begin
    if (key_length_r == 8'd0) begin
      exp_stat = STAT_LEN_ZERO;
    end else if (key_length_r > MAX_KEY_BYTES) begin
      exp_stat = STAT_LEN_LONG;
    end else if (eff_bits_r == 11'd0 || eff_bits_r > {key_length_r, 3'b000}) begin
      exp_stat = STAT_EFF_LONG;
    end else begin
      exp_stat = STAT_OK;
    end
  end

  assign t8_w     = 9'((12'({1'b0, eff_bits_r}) + 12'd7) >> 3);
  assign t8       = t8_w[7:0];
  assign mask_pos = 8'd128 - t8;
  assign tm       = 8'hFF >> (3'd0 - eff_bits_r[2:0]);

  assign copy_last  = idx_r == (key_length_r - 8'd1);
  assign fwd_last   = idx_r[6:0] == 7'd127;
  assign bwd_last   = idx_r == 8'd0;
  assign pack_last  = cnt_r == 6'd63;
  assign mash_point = cnt_r[1:0] == 2'd3 && (cnt_r[5:2] == 4'd4 || cnt_r[5:2] == 4'd10);
  assign mash_last  = idx_r[1:0] == 2'd3;

  assign pi_val = PI_TABLE[pi_idx];

  // Round unit operand selection: decrypt walks the words from the top.
  assign wi   = dec_r ? ~cnt_r[1:0] : cnt_r[1:0];
  assign wa   = wi + 2'd3;
  assign wb   = wi + 2'd2;
  assign wc   = wi + 2'd1;
  assign mixv = (r_r[wa] & r_r[wb]) + (~r_r[wa] & r_r[wc]);
  assign wm   = dec_r ? ~idx_r[1:0] : idx_r[1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_data.operation)
            OP_EXPAND:  state_nxt = (exp_stat == STAT_OK) ? ST_COPY : ST_DONE;
            OP_ENCRYPT: state_nxt = ST_CIPH;
            OP_DECRYPT: state_nxt = ST_CIPH;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_COPY: begin
        if (ph_r[0] && copy_last) begin
          state_nxt = key_length_r[7] ? ST_MASK : ST_FWD;
        end
      end
      ST_FWD:  if (ph_r[0] && fwd_last) state_nxt = ST_MASK;
      ST_MASK: if (ph_r[0]) state_nxt = (mask_pos == 8'd0) ? ST_PACK : ST_BWD;
      ST_BWD:  if (ph_r[0] && bwd_last) state_nxt = ST_PACK;
      ST_PACK: if (ph_r == 2'd2 && pack_last) state_nxt = ST_DONE;
      ST_CIPH: begin
        if (ph_r[0]) begin
          if (mash_point) begin
            state_nxt = ST_MASH;
          end else if (cnt_r == 6'd63) begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_MASH: if (ph_r[0] && mash_last) state_nxt = ST_CIPH;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    ph_nxt        = ph_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    prev_nxt      = prev_r;
    lo_nxt        = lo_r;
    dec_nxt       = dec_r;
    stat_nxt      = stat_r;
    r_nxt         = r_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    raw_we        = 1'b0;
    l_we          = 1'b0;
    ek_we         = 1'b0;
    l_raddr       = idx_r[6:0];
    l_waddr       = idx_r[6:0];
    l_wdata       = pi_val;
    ek_raddr      = cnt_r;
    pi_idx        = prev_r + l_q;
    case (state_r)
      ST_IDLE: begin
        ph_nxt = 2'd0;
        if (in_fire) begin
          case (in_data.operation)
            OP_WRITE: raw_we = 1'b1;
            OP_EXPAND: begin
              stat_nxt = exp_stat;
              idx_nxt  = 8'd0;
              for (int w = 0; w < 4; w++) r_nxt[w] = 16'd0;
            end
            default: begin
              stat_nxt = STAT_OK;
              dec_nxt  = in_data.operation == OP_DECRYPT;
              cnt_nxt  = 6'd0;
              for (int w = 0; w < 4; w++) r_nxt[w] = in_data.block_in[16*w +: 16];
            end
          endcase
        end
      end
      ST_COPY: begin
        // raw key read issued in phase 0, copied in phase 1
        if (ph_r[0]) begin
          l_we     = 1'b1;
          l_wdata  = raw_q;
          prev_nxt = raw_q;
          idx_nxt  = idx_r + 8'd1;
        end
        ph_nxt = {1'b0, ~ph_r[0]};
      end
      ST_FWD: begin
        l_raddr = 7'(idx_r - key_length_r);
        if (ph_r[0]) begin
          l_we     = 1'b1;
          prev_nxt = pi_val;
          idx_nxt  = idx_r + 8'd1;
        end
        ph_nxt = {1'b0, ~ph_r[0]};
      end
      ST_MASK: begin
        l_raddr = mask_pos[6:0];
        l_waddr = mask_pos[6:0];
        pi_idx  = l_q & tm;
        if (ph_r[0]) begin
          l_we     = 1'b1;
          prev_nxt = pi_val;
          idx_nxt  = mask_pos - 8'd1;
          cnt_nxt  = 6'd0;
        end
        ph_nxt = {1'b0, ~ph_r[0]};
      end
      ST_BWD: begin
        l_raddr = 7'(idx_r + t8);
        pi_idx  = prev_r ^ l_q;
        if (ph_r[0]) begin
          l_we     = 1'b1;
          prev_nxt = pi_val;
          idx_nxt  = idx_r - 8'd1;
          cnt_nxt  = 6'd0;
        end
        ph_nxt = {1'b0, ~ph_r[0]};
      end
      ST_PACK: begin
        case (ph_r)
          2'd0: begin
            l_raddr = {cnt_r, 1'b0};
            ph_nxt  = 2'd1;
          end
          2'd1: begin
            lo_nxt  = l_q;
            l_raddr = {cnt_r, 1'b1};
            ph_nxt  = 2'd2;
          end
          default: begin
            ek_we   = 1'b1;
            cnt_nxt = cnt_r + 6'd1;
            ph_nxt  = 2'd0;
          end
        endcase
      end
      ST_CIPH: begin
        ek_raddr = dec_r ? ~cnt_r : cnt_r;
        if (ph_r[0]) begin
          if (dec_r) begin
            r_nxt[wi] = rotr16(r_r[wi], wi) - ek_q - mixv;
          end else begin
            r_nxt[wi] = rotl16(r_r[wi] + ek_q + mixv, wi);
          end
          if (mash_point) begin
            idx_nxt = 8'd0;
          end else begin
            cnt_nxt = cnt_r + 6'd1;
          end
        end
        ph_nxt = {1'b0, ~ph_r[0]};
      end
      ST_MASH: begin
        ek_raddr = r_r[wm + 2'd3][5:0];
        if (ph_r[0]) begin
          r_nxt[wm] = dec_r ? (r_r[wm] - ek_q) : (r_r[wm] + ek_q);
          if (mash_last) begin
            cnt_nxt = cnt_r + 6'd1;
          end else begin
            idx_nxt = idx_r + 8'd1;
          end
        end
        ph_nxt = {1'b0, ~ph_r[0]};
      end
      ST_DONE: begin
        // hold the result here until the output register frees up
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.block_out = {r_r[3], r_r[2], r_r[1], r_r[0]};
          out_data_nxt.status    = stat_r;
        end
      end
      default: ph_nxt = 2'd0;
    endcase
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      ph_r         <= 2'd0;
      out_valid_r  <= 1'b0;
      key_length_r <= KEY_LENGTH_RST;
      eff_bits_r   <= EFF_BITS_RST;
    end else begin
      state_r     <= state_nxt;
      ph_r        <= ph_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_KEY_LENGTH: key_length_r <= cfg_wdata[7:0];
          CFG_EFF_BITS:   eff_bits_r   <= cfg_wdata;
          default:        key_length_r <= key_length_r;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    cnt_r      <= cnt_nxt;
    prev_r     <= prev_nxt;
    lo_r       <= lo_nxt;
    dec_r      <= dec_nxt;
    stat_r     <= stat_nxt;
    r_r        <= r_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (raw_we) raw_mem[in_data.key_index] <= in_data.key_byte;
    raw_q <= raw_mem[idx_r[6:0]];
  end

  always_ff @(posedge clk) begin
    if (l_we) l_mem[l_waddr] <= l_wdata;
    l_q <= l_mem[l_raddr];
  end

  always_ff @(posedge clk) begin
    if (ek_we) ek_mem[cnt_r] <= {l_q, lo_r};
    ek_q <= ek_mem[ek_raddr];
  end

endmodule

### hdl/rc2_chk.sv
// rc2_chk: port-level checks for rc2_block_cipher, attached by bind.
// Depends on rc2_pkg.
module rc2_chk (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input rc2_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_ready,
  input rc2_pkg::out_t out_data
);
  import rc2_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Expand or cipher transfers make the engine busy.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation != OP_WRITE |=> !in_ready)
    else $error("engine ready right after a work transfer");

  // Key writes leave the engine ready.
  a_write_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.operation == OP_WRITE |=> in_ready)
    else $error("key write made the engine busy");

  // An error status carries a zero block.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != STAT_OK |-> out_data.block_out == 64'd0)
    else $error("error status with nonzero block");

endmodule

bind rc2_block_cipher rc2_chk u_rc2_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### tb/sv/rc2_block_cipher_checker.sv
// rc2_block_cipher_checker: watches the input and result channels of the RC2 engine,
// predicts each result with its own key schedule and cipher, and counts mismatches.
// Depends on rc2_pkg for the payload types and codes.
module rc2_block_cipher_checker (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  rc2_pkg::in_t  in_data,
  input  logic          out_valid,
  input  logic          out_ready,
  input  rc2_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [10:0]   cfg_wdata,
  output int            fail_count,
  output int            pending,
  output int            result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import rc2_pkg::*;

  logic [7:0]  key_len_q;
  logic [10:0] eff_bits_q;
  logic [7:0]  key_bytes [128];
  logic [15:0] sched [64];
  out_t        result_queue [$];

  function automatic logic [15:0] mix_fn(logic [15:0] r [4], int w);
    logic [15:0] a, b, c;
    a = r[(w + 3) & 3];
    b = r[(w + 2) & 3];
    c = r[(w + 1) & 3];
    return (a & b) + (~a & c);
  endfunction

  function automatic logic [15:0] rol(logic [15:0] x, int s);
    return (x << s) | (x >> (16 - s));
  endfunction

  function automatic logic [1:0] expand_schedule();
    logic [7:0] l [128];
    int len, eff, t8, i;
    logic [7:0] tm;
    len = key_len_q;
    eff = eff_bits_q;
    if (len == 0) return STAT_LEN_ZERO;
    if (len > MAX_KEY_BYTES) return STAT_LEN_LONG;
    if (eff == 0 || eff > 8 * len) return STAT_EFF_LONG;
    for (i = 0; i < 128; i++) l[i] = (i < len) ? key_bytes[i] : 8'h00;
    t8 = (eff + 7) / 8;
    tm = 8'((9'd1 << (8 + eff - 8 * t8)) - 1);
    for (i = len; i < 128; i++) l[i] = PI_TABLE[8'(l[i - 1] + l[i - len])];
    l[128 - t8] = PI_TABLE[l[128 - t8] & tm];
    for (i = 127 - t8; i >= 0; i--) l[i] = PI_TABLE[l[i + 1] ^ l[i + t8]];
    for (i = 0; i < 64; i++) sched[i] = {l[2 * i + 1], l[2 * i]};
    return STAT_OK;
  endfunction

  function automatic logic [63:0] cipher_block(logic [63:0] blk, bit decrypt);
    logic [15:0] r [4];
    int rot [4] = '{1, 2, 3, 5};
    int i, w, j;
    for (w = 0; w < 4; w++) r[w] = blk[16 * w +: 16];
    j = decrypt ? 63 : 0;
    for (i = 0; i < 16; i++) begin
      if (!decrypt) begin
        for (w = 0; w < 4; w++) begin
          r[w] = rol(r[w] + sched[j] + mix_fn(r, w), rot[w]);
          j++;
        end
        if (i == 4 || i == 10)
          for (w = 0; w < 4; w++) r[w] = r[w] + sched[r[(w + 3) & 3][5:0]];
      end else begin
        for (w = 3; w >= 0; w--) begin
          r[w] = rol(r[w], 16 - rot[w]);
          r[w] = r[w] - sched[j] - mix_fn(r, w);
          j--;
        end
        if (i == 4 || i == 10)
          for (w = 3; w >= 0; w--) r[w] = r[w] - sched[r[(w + 3) & 3][5:0]];
      end
    end
    return {r[3], r[2], r[1], r[0]};
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending = result_queue.size();

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      key_len_q = KEY_LENGTH_RST;
      eff_bits_q = EFF_BITS_RST;
      fail_count = 0;
      result_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_KEY_LENGTH) key_len_q = cfg_wdata[7:0];
        else eff_bits_q = cfg_wdata;
      end
      // Check the result before queuing a new one from the same edge.
      if (out_valid && out_ready) begin
        result_count++;
        if (result_queue.size() == 0) begin
          report_mismatch("unexpected result", out_data.block_out, 64'd0);
        end else begin
          want = result_queue.pop_front();
          if (out_data.block_out !== want.block_out)
            report_mismatch("block_out", out_data.block_out, want.block_out);
          if (out_data.status !== want.status)
            report_mismatch("status", 64'(out_data.status), 64'(want.status));
        end
      end
      if (in_valid && in_ready) begin
        case (in_data.operation)
          OP_WRITE: key_bytes[in_data.key_index] = in_data.key_byte;
          OP_EXPAND: begin
            want.block_out = '0;
            want.status = expand_schedule();
            result_queue.push_back(want);
          end
          default: begin
            want.block_out = cipher_block(in_data.block_in, in_data.operation == OP_DECRYPT);
            want.status = STAT_OK;
            result_queue.push_back(want);
          end
        endcase
      end
    end
  end
endmodule

### tb/sv/rc2_block_cipher_test.sv
// rc2_block_cipher_test: top of the RC2 engine testbench; drives key writes, expands,
// encrypts, decrypts and register writes. Depends on rc2_pkg, rc2_block_cipher and
// rc2_block_cipher_checker.
module rc2_block_cipher_test;
  timeunit 1ns;
  timeprecision 1ps;
  import rc2_pkg::*;

  localparam int IDLE_FLUSH = 1000;  // longer than a full key expansion
  localparam int STALL_LIMIT = 20000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  in_t in_data;
  out_t out_data;
  logic cfg_we, cfg_index;
  logic [10:0] cfg_wdata;
  int fail_count, pending, result_count;
  int idle_cycles;
  int encrypts, decrypts, expands, key_writes;
  bit key_ready;  // set once a successful expand has filled the schedule

  rc2_block_cipher dut (.*);
  rc2_block_cipher_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Mostly short gaps, a few long ones, and stretches with none.
  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Randomly stall the result side.
  initial begin
    int stall;
    out_ready = 0;
    @(posedge clk iff rst_n);
    out_ready <= 1;
    forever begin
      @(posedge clk iff out_valid);
      if ($urandom_range(0, 3) == 0) begin
        stall = gap_len();
        if (stall > 0) begin
          out_ready <= 0;
          repeat (stall) @(posedge clk);
          out_ready <= 1;
        end
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("rc2_block_cipher_test failed");
      $finish;
    end
  end

  // Valid stays up after a transfer until the next item or an idle gap drops it.
  task automatic send(in_t item);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_data <= item;
    @(posedge clk iff in_ready);
    case (item.operation)
      OP_WRITE: key_writes++;
      OP_EXPAND: expands++;
      OP_ENCRYPT: encrypts++;
      default: decrypts++;
    endcase
  endtask

  task automatic write_key_byte(int idx, logic [7:0] b);
    in_t it;
    it = '0;
    it.operation = OP_WRITE;
    it.key_index = 7'(idx);
    it.key_byte = b;
    send(it);
  endtask

  task automatic cipher_op(logic [1:0] op, logic [63:0] blk);
    in_t it;
    it = '{operation: op, key_index: 7'($urandom), key_byte: 8'($urandom), block_in: blk};
    send(it);
  endtask

  task automatic expand_op();
    in_t it;
    it = '{operation: OP_EXPAND, key_index: 7'($urandom), key_byte: 8'($urandom),
           block_in: {$urandom, $urandom}};
    send(it);
  endtask

  // Hold off until the engine is drained, then write a register.
  task automatic write_reg(logic idx, logic [10:0] val);
    in_valid <= 0;
    @(posedge clk iff pending == 0);
    repeat (IDLE_FLUSH) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Load random bytes into the first n key store entries.
  task automatic fill_key(int n);
    for (int i = 0; i < n; i++) write_key_byte(i, 8'($urandom));
  endtask

  // Set up a key schedule and run a burst of blocks through it.
  task automatic key_phase(int len, int eff, int blocks);
    logic [63:0] blk;
    write_reg(CFG_KEY_LENGTH, 11'(len));
    write_reg(CFG_EFF_BITS, 11'(eff));
    expand_op();
    if (len >= 1 && len <= 128 && eff >= 1 && eff <= 8 * len) key_ready = 1;
    if (!key_ready) return;
    for (int b = 0; b < blocks; b++) begin
      // Occasional rewrite of a key byte without expanding: no effect on ciphering.
      if ($urandom_range(0, 15) == 0) write_key_byte($urandom_range(0, 127), 8'($urandom));
      blk = {$urandom, $urandom};
      if ($urandom_range(0, 7) == 0) blk = $urandom_range(0, 1) ? '1 : '0;
      cipher_op($urandom_range(0, 1) ? OP_ENCRYPT : OP_DECRYPT, blk);
    end
  endtask

  initial begin
    int len, eff;
    rst_n = 0;
    in_valid = 0;
    in_data = '0;
    cfg_we = 0;
    cfg_index = CFG_KEY_LENGTH;
    cfg_wdata = '0;
    key_ready = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: full key store, reset-value expand, field extremes, every status.
    fill_key(128);
    expand_op();
    key_ready = 1;
    cipher_op(OP_ENCRYPT, '0);
    cipher_op(OP_ENCRYPT, '1);
    cipher_op(OP_DECRYPT, '0);
    cipher_op(OP_DECRYPT, '1);
    write_key_byte(127, 8'hFF);
    write_key_byte(0, 8'h00);
    key_phase(0, 8, 0);        // key length zero
    key_phase(129, 8, 0);      // key too long
    key_phase(255, 1024, 2);   // key too long, largest key length
    key_phase(1, 9, 2);        // effective bits above eight per byte
    key_phase(128, 1024, 2);   // largest valid key
    key_phase(1, 1, 2);        // smallest key and mask
    key_phase(128, 1, 2);

    // Random: mostly valid key settings, some deliberately rejected.
    while (key_writes + encrypts + decrypts + expands < 800) begin
      len = $urandom_range(1, 128);
      eff = $urandom_range(1, 8 * len);
      case ($urandom_range(0, 9))
        0: len = 0;
        1: len = $urandom_range(129, 255);
        2: eff = $urandom_range(8 * len + 1, 1024 + 8 * len) % 2048;
        default: ;
      endcase
      if (eff == 0) eff = 2047;
      if ($urandom_range(0, 3) == 0) fill_key(len > 128 ? 128 : len);
      key_phase(len, eff, $urandom_range(5, 40));
    end
    in_valid <= 0;

    @(posedge clk iff pending == 0);
    repeat (IDLE_FLUSH) @(posedge clk);
    $display("covered %0d key writes, %0d expands, %0d encrypts, %0d decrypts",
             key_writes, expands, encrypts, decrypts);
    $display("%0d results checked, %0d mismatches", result_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("rc2_block_cipher_test passed");
    end else begin
      $display("rc2_block_cipher_test failed");
    end
    $finish;
  end
endmodule
